// ===== src/tlic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlic_pkg
// Shared types and constants for the two-level interrupt priority controller.
// ----------------------------------------------------------------------------
package tlic_pkg;

    localparam int VEC_W           = 6;
    localparam int REQ_W           = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 6;
    localparam int NUM_VECTORS_DEF = 64;

    // in-service level codes
    localparam int PRIO_LEVEL1 = 1;
    localparam int PRIO_LEVEL0 = 0;

    typedef enum logic [REQ_W-1:0] {
        REQ_QUERY = 3'd0,
        REQ_RAISE = 3'd1,
        REQ_CLEAR = 3'd2,
        REQ_ACK   = 3'd3,
        REQ_RETI  = 3'd4
    } req_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_PRIO = 1'b0,
        CFG_RR_START  = 1'b1
    } cfg_idx_t;

endpackage

// ===== src/tlic_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlic_req_if
// Event channel: request code and vector with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlic_req_if;

    logic                          valid;
    logic                          ready;
    logic [tlic_pkg::REQ_W-1:0]    req_type;
    logic [tlic_pkg::VEC_W-1:0]    vector;

    modport source (output valid, output req_type, output vector, input ready);
    modport sink   (input valid, input req_type, input vector, output ready);

endinterface

// ===== src/tlic_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlic_rsp_if
// Result channel: next vector and in-service flags with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlic_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [tlic_pkg::VEC_W-1:0]    next_vector;
    logic                          has_next;
    logic                          level0_active;
    logic                          level1_active;

    modport source (output valid, output next_vector, output has_next,
                    output level0_active, output level1_active, input ready);
    modport sink   (input valid, input next_vector, input has_next,
                    input level0_active, input level1_active, output ready);

endinterface

// ===== src/two_level_interrupt_priority_ctrl_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_interrupt_priority_ctrl_top
// Interrupt controller with one high-priority vector and round-robin
// selection among the other pending vectors.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req       in    valid / ready    req_type, vector
//  rsp       out   valid / ready    next_vector, has_next, level0/1_active
//  cfg       in    cfg_we           cfg_idx, cfg_wdata
//
//  one transaction per cycle sustained while rsp does not stall; rsp valid follows req
//  acceptance via the input register, then the result register
//  the pending bits and in-service flags update as an event moves from the
//  input register into the result register; the rotating encoder sits there
//  rsp stall holds the result register; the input register still takes one
//  more transaction, then req.ready drops
//  rst_n clears all pending bits, flags and both config registers
// ----------------------------------------------------------------------------
module two_level_interrupt_priority_ctrl_top #(
    parameter int NUM_VECTORS = tlic_pkg::NUM_VECTORS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tlic_req_if.sink                         req,
    tlic_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [tlic_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [tlic_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W   = $clog2(NUM_VECTORS);
    localparam int VEC_W   = tlic_pkg::VEC_W;
    localparam int LUT_LEN = 2 ** VEC_W;

    // configuration
    logic [VEC_W-1:0] high_prio_reg;
    logic [VEC_W-1:0] rr_start_reg;

    // input stage
    logic                    in_valid_reg;
    tlic_pkg::req_code_t     in_req_reg;
    logic [VEC_W-1:0]        in_vec_reg;

    // controller state
    logic [NUM_VECTORS-1:0]  pending_reg;
    logic [NUM_VECTORS-1:0]  pending_next;
    logic                    l0_reg;
    logic                    l0_next;
    logic                    l1_reg;
    logic                    l1_next;

    // result stage
    logic                    out_valid_reg;
    logic [VEC_W-1:0]        out_vec_reg;
    logic [VEC_W-1:0]        out_vec_next;
    logic                    out_has_reg;
    logic                    out_has_next;
    logic                    out_l0_reg;
    logic                    out_l1_reg;

    logic                    advance;
    logic                    in_range;
    logic [IDX_W-1:0]        bit_idx;
    logic [IDX_W-1:0]        start_idx;
    logic [IDX_W-1:0]        lo_idx;
    logic                    lo_found;
    logic [IDX_W-1:0]        rot_idx;
    logic                    rot_found;
    logic                    high_pend;

    logic [IDX_W-1:0]        start_lut [LUT_LEN];

    // search start for each start register value: zero stays zero, else value plus one, modulo the vector count
    for (genvar k = 0; k < LUT_LEN; k++) begin : g_start
        localparam int START = (k == 0) ? 0 : ((k + 1) % NUM_VECTORS);
        assign start_lut[k] = IDX_W'(START);
    end

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    assign in_range  = {1'b0, in_vec_reg} < (VEC_W + 1)'(NUM_VECTORS);
    assign bit_idx   = in_vec_reg[IDX_W-1:0];
    assign start_idx = start_lut[rr_start_reg];

    // event update
    always_comb
    begin
        pending_next = pending_reg;
        l0_next      = l0_reg;
        l1_next      = l1_reg;
        unique case (in_req_reg)
            tlic_pkg::REQ_RAISE:
            begin
                if (in_range)
                begin
                    pending_next[bit_idx] = 1'b1;
                end
            end
            tlic_pkg::REQ_CLEAR:
            begin
                if (in_range)
                begin
                    pending_next[bit_idx] = 1'b0;
                end
            end
            tlic_pkg::REQ_ACK:
            begin
                if (in_range)
                begin
                    if (in_vec_reg != '0)
                    begin
                        if (in_vec_reg == high_prio_reg)
                        begin
                            l1_next = 1'b1;
                        end
                        else
                        begin
                            l0_next = 1'b1;
                        end
                    end
                    pending_next[bit_idx] = 1'b1;
                end
            end
            tlic_pkg::REQ_RETI:
            begin
                if (l1_reg)
                begin
                    l1_next = 1'b0;
                end
                else
                begin
                    l0_next = 1'b0;
                end
            end
            default:
            begin
                // query and unused codes change nothing
            end
        endcase
    end

    // rotating priority encoder: lowest pending at or above start, else lowest
    always_comb
    begin
        lo_idx    = '0;
        lo_found  = 1'b0;
        rot_idx   = '0;
        rot_found = 1'b0;
        for (int i = NUM_VECTORS - 1; i >= 0; i--)
        begin
            if (pending_next[i])
            begin
                lo_idx   = IDX_W'(i);
                lo_found = 1'b1;
                if (IDX_W'(i) >= start_idx)
                begin
                    rot_idx   = IDX_W'(i);
                    rot_found = 1'b1;
                end
            end
        end
    end

    assign high_pend = (high_prio_reg != '0)
                    && ({1'b0, high_prio_reg} < (VEC_W + 1)'(NUM_VECTORS))
                    && pending_next[high_prio_reg[IDX_W-1:0]];

    always_comb
    begin
        out_vec_next = '0;
        out_has_next = 1'b0;
        priority if (l1_next)
        begin
            out_has_next = 1'b0;
        end
        else if (high_pend)
        begin
            out_vec_next = high_prio_reg;
            out_has_next = 1'b1;
        end
        else if (l0_next)
        begin
            out_has_next = 1'b0;
        end
        else if (rot_found)
        begin
            out_vec_next = VEC_W'(rot_idx);
            out_has_next = 1'b1;
        end
        else if (lo_found)
        begin
            out_vec_next = VEC_W'(lo_idx);
            out_has_next = 1'b1;
        end
        else
        begin
            out_has_next = 1'b0;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_prio_reg <= '0;
            rr_start_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (tlic_pkg::cfg_idx_t'(cfg_idx))
                tlic_pkg::CFG_HIGH_PRIO: high_prio_reg <= VEC_W'(cfg_wdata);
                tlic_pkg::CFG_RR_START:  rr_start_reg  <= VEC_W'(cfg_wdata);
                default:                 ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            l0_reg        <= 1'b0;
            l1_reg        <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= pending_next;
                l0_reg        <= l0_next;
                l1_reg        <= l1_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_req_reg <= tlic_pkg::req_code_t'(req.req_type);
            in_vec_reg <= req.vector;
        end
        if (advance)
        begin
            out_vec_reg <= out_vec_next;
            out_has_reg <= out_has_next;
            out_l0_reg  <= l0_next;
            out_l1_reg  <= l1_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.next_vector   = out_vec_reg;
    assign rsp.has_next      = out_has_reg;
    assign rsp.level0_active = out_l0_reg;
    assign rsp.level1_active = out_l1_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-level interrupt controller against a cycle-free predictor.
// A directed table comes first, followed by random event streams under six
// priority and rotation settings. The sender works in bursts and the
// receiver stalls, and every result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NVEC = tlic_pkg::NUM_VECTORS_DEF;
    localparam int REQ_W = tlic_pkg::REQ_W;
    localparam int VEC_W = tlic_pkg::VEC_W;
    localparam int CFG_IDX_W = tlic_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tlic_pkg::CFG_DATA_W;
    localparam int DIR_ROWS = 27;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_EVENTS = 210;

    // request codes that the block treats as a query
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    localparam logic [REQ_W-1:0] OP_HIGH_PRIO = REQ_W'(tlic_pkg::CFG_HIGH_PRIO);
    localparam logic [REQ_W-1:0] OP_RR_START  = REQ_W'(tlic_pkg::CFG_RR_START);

    typedef struct packed {
        logic [VEC_W-1:0] next_vector;
        logic             has_next;
        logic             level0_active;
        logic             level1_active;
    } irq_status_t;

    typedef enum bit {ROW_EVENT, ROW_CFG} row_kind_t;

    // for a register row, op holds the register index and arg the value
    typedef struct packed {
        row_kind_t        kind;
        logic [REQ_W-1:0] op;
        logic [VEC_W-1:0] arg;
        bit               pinned;
        irq_status_t      want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tlic_req_if req_ch();
    tlic_rsp_if rsp_ch();

    two_level_interrupt_priority_ctrl_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [NVEC-1:0]  pend_mask;
    logic             svc_l0;
    logic             svc_l1;
    logic [VEC_W-1:0] hp_vec;
    logic [VEC_W-1:0] rr_start;
    irq_status_t      last_status;

    irq_status_t status_due[$];
    int err_count;
    int events_sent;
    int statuses_checked;
    int hp_grants;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_EVENT, tlic_pkg::REQ_QUERY, 6'd0,  1'b1, '{6'd0,  1'b0, 1'b0, 1'b0}},
        '{ROW_EVENT, tlic_pkg::REQ_RAISE, 6'd63, 1'b1, '{6'd63, 1'b1, 1'b0, 1'b0}},
        '{ROW_EVENT, tlic_pkg::REQ_RAISE, 6'd0,  1'b1, '{6'd0,  1'b1, 1'b0, 1'b0}},
        // acknowledge of vector zero touches no in-service flag
        '{ROW_EVENT, tlic_pkg::REQ_ACK,   6'd0,  1'b1, '{6'd0,  1'b1, 1'b0, 1'b0}},
        '{ROW_EVENT, tlic_pkg::REQ_CLEAR, 6'd0,  1'b1, '{6'd63, 1'b1, 1'b0, 1'b0}},
        '{ROW_EVENT, tlic_pkg::REQ_ACK,   6'd63, 1'b1, '{6'd0,  1'b0, 1'b1, 1'b0}},
        '{ROW_EVENT, tlic_pkg::REQ_RETI,  6'd0,  1'b1, '{6'd63, 1'b1, 1'b0, 1'b0}},
        // return with nothing in service
        '{ROW_EVENT, tlic_pkg::REQ_RETI,  6'd0,  1'b1, '{6'd63, 1'b1, 1'b0, 1'b0}},
        '{ROW_EVENT, REQ_UNUSED_HI,       6'd63, 1'b1, '{6'd63, 1'b1, 1'b0, 1'b0}},
        '{ROW_EVENT, tlic_pkg::REQ_CLEAR, 6'd63, 1'b1, '{6'd0,  1'b0, 1'b0, 1'b0}},
        '{ROW_CFG,   OP_HIGH_PRIO,        6'd42, 1'b0, '0},
        '{ROW_CFG,   OP_RR_START,         6'd21, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RAISE, 6'd3,  1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RAISE, 6'd30, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RAISE, 6'd42, 1'b0, '0},
        // high vector preempts an active level 0
        '{ROW_EVENT, tlic_pkg::REQ_ACK,   6'd30, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_ACK,   6'd42, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RAISE, 6'd21, 1'b0, '0},
        '{ROW_EVENT, REQ_UNUSED_LO,       6'd21, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RETI,  6'd0,  1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_CLEAR, 6'd42, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RETI,  6'd0,  1'b0, '0},
        // start at the top vector wraps the search round to zero
        '{ROW_CFG,   OP_RR_START,         6'd63, 1'b0, '0},
        '{ROW_CFG,   OP_HIGH_PRIO,        6'd63, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_QUERY, 6'd0,  1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_ACK,   6'd63, 1'b0, '0},
        '{ROW_EVENT, tlic_pkg::REQ_RETI,  6'd0,  1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic irq_status_t apply_event(logic [REQ_W-1:0] code,
                                                logic [VEC_W-1:0] vec);
        irq_status_t res;
        int          i;
        int          idx;
        bit          found;
        bit          in_range;
        in_range = vec < NVEC;
        case (code)
            tlic_pkg::REQ_RAISE:
                if (in_range)
                    pend_mask[vec] = 1'b1;
            tlic_pkg::REQ_CLEAR:
                if (in_range)
                    pend_mask[vec] = 1'b0;
            tlic_pkg::REQ_ACK:
                if (in_range)
                begin
                    if (vec != 0)
                    begin
                        if (vec == hp_vec)
                            svc_l1 = 1'b1;
                        else
                            svc_l0 = 1'b1;
                    end
                    pend_mask[vec] = 1'b1;
                end
            tlic_pkg::REQ_RETI:
                if (svc_l1)
                    svc_l1 = 1'b0;
                else
                    svc_l0 = 1'b0;
            default:
                ;
        endcase

        res = '0;
        found = 1'b0;
        if (!svc_l1)
        begin
            if (hp_vec != 0 && hp_vec < NVEC && pend_mask[hp_vec])
            begin
                res.next_vector = hp_vec;
                found = 1'b1;
                hp_grants++;
            end
            else if (!svc_l0)
            begin
                for (i = 0; i < NVEC && !found; i++)
                begin
                    idx = (rr_start == 0) ? i : (i + 1 + rr_start) % NVEC;
                    if (pend_mask[idx])
                    begin
                        res.next_vector = idx[VEC_W-1:0];
                        found = 1'b1;
                    end
                end
            end
        end
        res.has_next = found;
        res.level0_active = svc_l0;
        res.level1_active = svc_l1;
        return res;
    endfunction

    task automatic send_item(logic [REQ_W-1:0] code, logic [VEC_W-1:0] vec, bit pinned,
                             irq_status_t want);
        irq_status_t pred;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= code;
        req_ch.vector <= vec;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = apply_event(code, vec);
        last_status = pred;
        status_due.push_back(pinned ? want : pred);
        events_sent++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // stop sending and wait until every outstanding transaction has returned
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(tlic_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == tlic_pkg::CFG_HIGH_PRIO)
            hp_vec = data;
        else
            rr_start = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly service-shaped traffic: raise, acknowledge what is offered,
    // clear it, return; plus queries and unused codes as noise
    task automatic pick_event(output logic [REQ_W-1:0] code, output logic [VEC_W-1:0] vec);
        int r;
        r = $urandom_range(0, 99);
        vec = VEC_W'($urandom_range(0, NVEC - 1));
        if (r < 25)
        begin
            code = tlic_pkg::REQ_RAISE;
            if (hp_vec != 0 && $urandom_range(0, 4) == 0)
                vec = hp_vec;
        end
        else if (r < 42)
        begin
            code = tlic_pkg::REQ_CLEAR;
            if (last_status.has_next && $urandom_range(0, 9) < 6)
                vec = last_status.next_vector;
        end
        else if (r < 62)
        begin
            code = tlic_pkg::REQ_ACK;
            if (last_status.has_next && $urandom_range(0, 9) < 8)
                vec = last_status.next_vector;
            else if ($urandom_range(0, 9) == 0)
                vec = '0;
        end
        else if (r < 80)
            code = tlic_pkg::REQ_RETI;
        else if (r < 94)
            code = tlic_pkg::REQ_QUERY;
        else
            code = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    endtask

    task automatic run_random_phase(int count, bit no_gaps);
        logic [REQ_W-1:0] code;
        logic [VEC_W-1:0] vec;
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count)
            begin
                pick_event(code, vec);
                send_item(code, vec, 1'b0, '0);
                sent++;
                burst--;
                if (sent == count / 2)
                    drain();
            end
            if (!no_gaps)
                idle_cycles($urandom_range(0, 6));
        end
    endtask

    // receiver: segments of always ready, random stalls, or a fixed stall pattern
    initial
    begin
        int mode;
        int left;
        int tick;
        rsp_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 150);
            end
            else
                left--;
            tick++;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 99) < 55);
                default: rsp_ch.ready <= (tick % 7) >= 3;
            endcase
        end
    end

    always @(posedge clk)
    begin : rsp_check
        irq_status_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $error("unexpected transaction: next_vector %0d has_next %0b",
                       rsp_ch.next_vector, rsp_ch.has_next);
                err_count++;
            end
            else
            begin
                want = status_due.pop_front();
                statuses_checked++;
                if (rsp_ch.next_vector !== want.next_vector)
                begin
                    $error("next_vector: expected %0d, got %0d",
                           want.next_vector, rsp_ch.next_vector);
                    err_count++;
                end
                if (rsp_ch.has_next !== want.has_next)
                begin
                    $error("has_next: expected %0b, got %0b", want.has_next, rsp_ch.has_next);
                    err_count++;
                end
                if (rsp_ch.level0_active !== want.level0_active)
                begin
                    $error("level0_active: expected %0b, got %0b",
                           want.level0_active, rsp_ch.level0_active);
                    err_count++;
                end
                if (rsp_ch.level1_active !== want.level1_active)
                begin
                    $error("level1_active: expected %0b, got %0b",
                           want.level1_active, rsp_ch.level1_active);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int ph;
        int row;
        logic [VEC_W-1:0] hp_set;
        logic [VEC_W-1:0] rr_set;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.vector = '0;
        pend_mask = '0;
        svc_l0 = 1'b0;
        svc_l1 = 1'b0;
        hp_vec = '0;
        rr_start = '0;
        last_status = '0;
        err_count = 0;
        events_sent = 0;
        statuses_checked = 0;
        hp_grants = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (dir_rows[row].kind == ROW_CFG)
            begin
                drain();
                write_reg(tlic_pkg::cfg_idx_t'(dir_rows[row].op[CFG_IDX_W-1:0]),
                          dir_rows[row].arg);
            end
            else
                send_item(dir_rows[row].op, dir_rows[row].arg, dir_rows[row].pinned,
                          dir_rows[row].want);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: begin hp_set = '0; rr_set = '0; end
                1: begin hp_set = '1; rr_set = '1; end
                3: begin hp_set = VEC_W'($urandom_range(1, NVEC - 1)); rr_set = '0; end
                4: begin hp_set = '0; rr_set = VEC_W'($urandom_range(1, NVEC - 1)); end
                default:
                begin
                    hp_set = VEC_W'($urandom_range(0, NVEC - 1));
                    rr_set = VEC_W'($urandom_range(0, NVEC - 1));
                end
            endcase
            drain();
            write_reg(tlic_pkg::CFG_HIGH_PRIO, hp_set);
            write_reg(tlic_pkg::CFG_RR_START, rr_set);
            run_random_phase(PHASE_EVENTS, ph == 1);
        end

        drain();
        repeat (8) @(posedge clk);
        if (status_due.size() != 0)
        begin
            $error("%0d expected transactions never returned", status_due.size());
            err_count++;
        end
        $display("sent %0d events: directed table plus %0d random phases, checked %0d results",
                 events_sent, RAND_PHASES, statuses_checked);
        $display("high-priority vector selected %0d times", hp_grants);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
